// ----- rtl/rv64ie_pkg.sv -----
// ----------------------------------------------------------------------------
// RV64I execute unit package
// Opcodes, status codes and the item types shared by the front and back parts.
// ----------------------------------------------------------------------------
package rv64ie_pkg;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;

    localparam logic [6:0]  FUNCT7_ALT  = 7'b0100000;
    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_ECALL   = 2'd1;
    localparam logic [1:0] ST_EBREAK  = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // Decoded item held in the queue between front and back.
    typedef struct packed {
        logic [6:0]  opcode;
        logic [2:0]  funct3;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic        alt;
        logic        is_ecall;
        logic        is_ebreak;
    } dec_t;

    // Result item.
    typedef struct packed {
        logic [31:0] inst_pc;
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  dest_reg;
        logic [63:0] dest_value;
        logic        mem_write;
        logic [31:0] mem_addr;
        logic [1:0]  status;
    } res_t;

endpackage

// ----- rtl/rv64ie_fifo.sv -----
// ----------------------------------------------------------------------------
// RV64I execute unit queue
// Small first-in first-out queue of items; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module rv64ie_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             pop,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == (PW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/rv64ie_decode.sv -----
// ----------------------------------------------------------------------------
// RV64I execute unit front decoder
// Splits an instruction word into fields and builds its immediate.
// ----------------------------------------------------------------------------
module rv64ie_decode (
    input  logic [31:0]        instr_word,
    output rv64ie_pkg::dec_t   dec
);

    logic [31:0] w;

    assign w = instr_word;

    always_comb
    begin
        dec.opcode    = w[6:0];
        dec.funct3    = w[14:12];
        dec.rd        = w[11:7];
        dec.rs1       = w[19:15];
        dec.rs2       = w[24:20];
        dec.is_ecall  = (w == rv64ie_pkg::WORD_ECALL);
        dec.is_ebreak = (w == rv64ie_pkg::WORD_EBREAK);
        dec.alt       = 1'b0;
        dec.imm       = '0;
        unique case (w[6:0])
            rv64ie_pkg::OP_REG:
            begin
                dec.alt = (w[31:25] == rv64ie_pkg::FUNCT7_ALT);
            end
            rv64ie_pkg::OP_IMM:
            begin
                // Bit 10 of the immediate picks the arithmetic right shift.
                dec.alt = w[30];
                dec.imm = {{20{w[31]}}, w[31:20]};
            end
            rv64ie_pkg::OP_LOAD, rv64ie_pkg::OP_JALR:
            begin
                dec.imm = {{20{w[31]}}, w[31:20]};
            end
            rv64ie_pkg::OP_STORE:
            begin
                dec.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            end
            rv64ie_pkg::OP_BRANCH:
            begin
                dec.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
            rv64ie_pkg::OP_LUI, rv64ie_pkg::OP_AUIPC:
            begin
                dec.imm = {w[31:12], 12'b0};
            end
            rv64ie_pkg::OP_JAL:
            begin
                dec.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            default:
            begin
                dec.imm = '0;
            end
        endcase
    end

endmodule

// ----- rtl/rv64ie_exec.sv -----
// ----------------------------------------------------------------------------
// RV64I execute unit back end
// Execute, memory and write-back stages with register file and data memory.
// ----------------------------------------------------------------------------
module rv64ie_exec #(
    parameter int DMEM_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  rv64ie_pkg::dec_t   q_data,
    output logic               q_pop,
    input  logic               o_full,
    output logic               o_push,
    output rv64ie_pkg::res_t   o_data,
    output logic               clr_busy
);

    localparam int AW   = $clog2(DMEM_BYTES);
    localparam int RW   = AW - 3;
    localparam int ROWS = DMEM_BYTES / 8;

    typedef struct packed {
        rv64ie_pkg::res_t res;
        logic             is_load;
        logic [2:0]       funct3;
        logic [63:0]      sdata;
    } mem_t;

    // Control and payload registers
    logic               ex_vld_reg;
    rv64ie_pkg::dec_t   ex_reg;
    logic               mem_vld_reg;
    mem_t               mem_reg;
    logic               wb_vld_reg;
    mem_t               wb_reg;
    logic [31:0]        pc_reg;
    logic               halted_reg;
    logic [RW:0]        clr_cnt_reg;

    logic [63:0]        rf_mem [32];
    logic [31:0]        rf_vld_reg;
    logic [63:0]        rf_rd1_reg;
    logic [63:0]        rf_rd2_reg;
    logic [7:0]         lane_q [8];

    logic               adv;
    logic               hazard;
    logic               ex_go;
    logic               ex_hold;
    logic [4:0]         ra1;
    logic [4:0]         ra2;
    logic               rf_we;
    logic [63:0]        wb_value;
    logic [63:0]        op_a;
    logic [63:0]        op_b;
    mem_t               mem_next;
    logic [31:0]        pc_next;
    logic               halted_next;
    logic [2:0]         mem_off;
    logic [RW-1:0]      mem_row;
    logic [63:0]        load_raw;

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    assign clr_busy = !clr_cnt_reg[RW];
    assign adv      = !(wb_vld_reg && o_full);
    // A load in the memory stage cannot yet hand its value to the item behind it.
    assign hazard   = ex_vld_reg && mem_vld_reg && mem_reg.is_load
                      && (mem_reg.res.dest_reg == ex_reg.rs1
                          || mem_reg.res.dest_reg == ex_reg.rs2);
    assign ex_go    = adv && ex_vld_reg && !hazard;
    assign ex_hold  = ex_vld_reg && !ex_go;
    assign q_pop    = adv && (!ex_vld_reg || ex_go) && !q_empty && !clr_busy;
    assign o_push   = wb_vld_reg && adv;
    assign rf_we    = o_push && wb_reg.res.reg_write;

    // ------------------------------------------------------------------
    // Register file: registered reads, written from write-back
    // ------------------------------------------------------------------
    assign ra1 = ex_hold ? ex_reg.rs1 : q_data.rs1;
    assign ra2 = ex_hold ? ex_reg.rs2 : q_data.rs2;

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[wb_reg.res.dest_reg] <= wb_value;
        end
        if (rf_we && wb_reg.res.dest_reg == ra1)
        begin
            rf_rd1_reg <= wb_value;
        end
        else
        begin
            rf_rd1_reg <= rf_vld_reg[ra1] ? rf_mem[ra1] : 64'd0;
        end
        if (rf_we && wb_reg.res.dest_reg == ra2)
        begin
            rf_rd2_reg <= wb_value;
        end
        else
        begin
            rf_rd2_reg <= rf_vld_reg[ra2] ? rf_mem[ra2] : 64'd0;
        end
    end

    // Operand forwarding from the memory and write-back stages.
    always_comb
    begin
        if (mem_vld_reg && mem_reg.res.reg_write && mem_reg.res.dest_reg == ex_reg.rs1)
        begin
            op_a = mem_reg.res.dest_value;
        end
        else if (wb_vld_reg && wb_reg.res.reg_write && wb_reg.res.dest_reg == ex_reg.rs1)
        begin
            op_a = wb_value;
        end
        else
        begin
            op_a = rf_rd1_reg;
        end
        if (mem_vld_reg && mem_reg.res.reg_write && mem_reg.res.dest_reg == ex_reg.rs2)
        begin
            op_b = mem_reg.res.dest_value;
        end
        else if (wb_vld_reg && wb_reg.res.reg_write && wb_reg.res.dest_reg == ex_reg.rs2)
        begin
            op_b = wb_value;
        end
        else
        begin
            op_b = rf_rd2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Execute stage
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [63:0] imm64;
        logic [63:0] alu_b;
        logic [5:0]  shamt;
        logic [63:0] alu_out;
        logic [63:0] addr_sum;
        logic [63:0] link;
        logic        take;
        logic        wr;
        logic [63:0] val;
        logic [1:0]  status;

        imm64    = {{32{ex_reg.imm[31]}}, ex_reg.imm};
        alu_b    = (ex_reg.opcode == rv64ie_pkg::OP_REG) ? op_b : imm64;
        shamt    = alu_b[5:0];
        addr_sum = op_a + imm64;
        link     = {32'd0, pc_reg} + 64'd4;
        pc_next  = pc_reg + 32'd4;
        take     = 1'b0;
        wr       = 1'b0;
        val      = '0;
        status   = rv64ie_pkg::ST_NORMAL;
        halted_next = halted_reg;

        case (ex_reg.funct3)
            3'd0:    alu_out = (ex_reg.opcode == rv64ie_pkg::OP_REG && ex_reg.alt)
                               ? op_a - alu_b : op_a + alu_b;
            3'd1:    alu_out = op_a << shamt;
            3'd2:    alu_out = {63'd0, $signed(op_a) < $signed(alu_b)};
            3'd3:    alu_out = {63'd0, op_a < alu_b};
            3'd4:    alu_out = op_a ^ alu_b;
            3'd5:    alu_out = ex_reg.alt ? 64'($signed(op_a) >>> shamt) : op_a >> shamt;
            3'd6:    alu_out = op_a | alu_b;
            default: alu_out = op_a & alu_b;
        endcase

        case (ex_reg.funct3)
            3'd0:    take = (op_a == op_b);
            3'd1:    take = (op_a != op_b);
            3'd4:    take = ($signed(op_a) < $signed(op_b));
            3'd5:    take = ($signed(op_a) >= $signed(op_b));
            3'd6:    take = (op_a < op_b);
            3'd7:    take = (op_a >= op_b);
            default: take = 1'b0;
        endcase

        mem_next.is_load       = 1'b0;
        mem_next.funct3        = ex_reg.funct3;
        mem_next.sdata         = op_b;
        mem_next.res.mem_write = 1'b0;
        mem_next.res.mem_addr  = '0;

        unique case (ex_reg.opcode)
            rv64ie_pkg::OP_REG, rv64ie_pkg::OP_IMM:
            begin
                wr  = 1'b1;
                val = alu_out;
            end
            rv64ie_pkg::OP_LOAD:
            begin
                wr = (ex_reg.funct3 != 3'd7);
                mem_next.res.mem_addr = addr_sum[31:0];
            end
            rv64ie_pkg::OP_STORE:
            begin
                mem_next.res.mem_write = !ex_reg.funct3[2];
                mem_next.res.mem_addr  = addr_sum[31:0];
            end
            rv64ie_pkg::OP_BRANCH:
            begin
                if (take)
                begin
                    pc_next = pc_reg + ex_reg.imm;
                end
            end
            rv64ie_pkg::OP_LUI:
            begin
                wr  = 1'b1;
                val = imm64;
            end
            rv64ie_pkg::OP_AUIPC:
            begin
                wr  = 1'b1;
                val = {32'd0, pc_reg} + imm64;
            end
            rv64ie_pkg::OP_JAL:
            begin
                wr      = 1'b1;
                val     = link;
                pc_next = pc_reg + ex_reg.imm;
            end
            rv64ie_pkg::OP_JALR:
            begin
                wr      = 1'b1;
                val     = link;
                pc_next = {addr_sum[31:1], 1'b0};
            end
            rv64ie_pkg::OP_SYSTEM:
            begin
                if (ex_reg.is_ecall)
                begin
                    status      = rv64ie_pkg::ST_ECALL;
                    pc_next     = pc_reg;
                    halted_next = 1'b1;
                end
                else if (ex_reg.is_ebreak)
                begin
                    status  = rv64ie_pkg::ST_EBREAK;
                    pc_next = pc_reg;
                end
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase

        wr = wr && (ex_reg.rd != 5'd0);
        mem_next.is_load        = wr && (ex_reg.opcode == rv64ie_pkg::OP_LOAD);
        mem_next.res.inst_pc    = pc_reg;
        mem_next.res.next_pc    = pc_next;
        mem_next.res.reg_write  = wr;
        mem_next.res.dest_reg   = wr ? ex_reg.rd : 5'd0;
        mem_next.res.dest_value = wr ? val : 64'd0;
        mem_next.res.status     = status;

        // A halted core reports the word as ignored and changes nothing.
        if (halted_reg)
        begin
            pc_next                 = pc_reg;
            mem_next.is_load        = 1'b0;
            mem_next.res.next_pc    = pc_reg;
            mem_next.res.reg_write  = 1'b0;
            mem_next.res.dest_reg   = '0;
            mem_next.res.dest_value = '0;
            mem_next.res.mem_write  = 1'b0;
            mem_next.res.mem_addr   = '0;
            mem_next.res.status     = rv64ie_pkg::ST_IGNORED;
        end
    end

    // ------------------------------------------------------------------
    // Memory stage: eight byte lanes, each with its own row address
    // ------------------------------------------------------------------
    assign mem_off = mem_reg.res.mem_addr[2:0];
    assign mem_row = mem_reg.res.mem_addr[AW-1:3];

    for (genvar gl = 0; gl < 8; gl++)
    begin : g_lane
        logic [7:0]    lane_mem [ROWS];
        logic [2:0]    k;
        logic [RW-1:0] row;
        logic          st_en;
        logic          we;
        logic [RW-1:0] waddr;
        logic [7:0]    wd;

        // Lanes below the start offset hold bytes from the following row.
        assign k     = 3'(gl) - mem_off;
        assign row   = mem_row + RW'(3'(gl) < mem_off);
        assign st_en = adv && mem_vld_reg && mem_reg.res.mem_write
                       && ({1'b0, k} < (4'd1 << mem_reg.funct3[1:0]));
        assign we    = clr_busy || st_en;
        assign waddr = clr_busy ? clr_cnt_reg[RW-1:0] : row;
        assign wd    = clr_busy ? 8'd0 : mem_reg.sdata[8*k +: 8];

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                lane_mem[waddr] <= wd;
            end
            if (adv)
            begin
                lane_q[gl] <= lane_mem[row];
            end
        end
    end

    // ------------------------------------------------------------------
    // Write-back stage: align and extend load data
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            load_raw[8*k +: 8] = lane_q[3'(wb_reg.res.mem_addr[2:0] + 3'(k))];
        end
        case (wb_reg.funct3)
            3'd0:    wb_value = {{56{load_raw[7]}}, load_raw[7:0]};
            3'd1:    wb_value = {{48{load_raw[15]}}, load_raw[15:0]};
            3'd2:    wb_value = {{32{load_raw[31]}}, load_raw[31:0]};
            3'd4:    wb_value = {56'd0, load_raw[7:0]};
            3'd5:    wb_value = {48'd0, load_raw[15:0]};
            3'd6:    wb_value = {32'd0, load_raw[31:0]};
            default: wb_value = load_raw;
        endcase
        if (!wb_reg.is_load)
        begin
            wb_value = wb_reg.res.dest_value;
        end
    end

    always_comb
    begin
        o_data            = wb_reg.res;
        o_data.dest_value = wb_value;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ex_reg <= q_data;
        end
        if (adv)
        begin
            mem_reg <= mem_next;
            wb_reg  <= mem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_vld_reg  <= 1'b0;
            mem_vld_reg <= 1'b0;
            wb_vld_reg  <= 1'b0;
            pc_reg      <= '0;
            halted_reg  <= 1'b0;
            clr_cnt_reg <= '0;
            rf_vld_reg  <= '0;
        end
        else
        begin
            if (clr_busy)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (q_pop)
            begin
                ex_vld_reg <= 1'b1;
            end
            else if (ex_go)
            begin
                ex_vld_reg <= 1'b0;
            end
            if (adv)
            begin
                mem_vld_reg <= ex_go;
                wb_vld_reg  <= mem_vld_reg;
            end
            if (ex_go)
            begin
                pc_reg     <= pc_next;
                halted_reg <= halted_next;
            end
            if (rf_we)
            begin
                rf_vld_reg[wb_reg.res.dest_reg] <= 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !q_pop)
        else $error("item taken during memory clearing");

    a_no_load_use_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_go && mem_vld_reg && mem_reg.is_load)
        |-> (mem_reg.res.dest_reg != ex_reg.rs1 && mem_reg.res.dest_reg != ex_reg.rs2))
        else $error("item executed on a load value not yet available");

    a_ecall_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_go && ex_reg.is_ecall && !halted_reg) |=> halted_reg)
        else $error("ecall did not halt");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(halted_reg))
        else $error("halted flag cleared without reset");

    a_x0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (wb_reg.res.dest_reg != 5'd0))
        else $error("write to x0");
`endif

endmodule

// ----- rtl/rv64i_instruction_execute_unit.sv -----
// ----------------------------------------------------------------------------
// RV64I instruction execute unit
// Executes one RV64I base integer instruction word per item.
// ----------------------------------------------------------------------------
// Each pushed item is one instruction word, executed at the internal program
// counter; one result item per word comes out in order. Sustained rate is one
// item per cycle while results are popped and no load holds the next item. An
// item passes the decoder into a two-entry queue, then the execute, memory and
// write-back stages and a two-entry result queue. A load whose destination is a
// source of the instruction right behind it holds that instruction in the
// execute stage until its data is read from the registered data memory. After
// reset the data memory is cleared one eight-byte row per cycle, and full stays
// high until that is done. DMEM_BYTES must be a power of two.
module rv64i_instruction_execute_unit #(
    parameter int DMEM_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] instr_word,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] inst_pc,
    output logic [31:0] next_pc,
    output logic        reg_write,
    output logic [4:0]  dest_reg,
    output logic [63:0] dest_value,
    output logic        mem_write,
    output logic [31:0] mem_addr,
    output logic [1:0]  status
);

    rv64ie_pkg::dec_t dec;
    rv64ie_pkg::dec_t q_data;
    rv64ie_pkg::res_t o_data;
    rv64ie_pkg::res_t res;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic             o_full;
    logic             o_push;
    logic             clr_busy;

    assign full = q_full || clr_busy;

    rv64ie_decode u_decode (
        .instr_word (instr_word),
        .dec        (dec)
    );

    rv64ie_fifo #(
        .WIDTH ($bits(rv64ie_pkg::dec_t)),
        .DEPTH (2)
    ) u_dec_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !clr_busy),
        .pop   (q_pop),
        .wdata (dec),
        .full  (q_full),
        .empty (q_empty),
        .rdata (q_data)
    );

    rv64ie_exec #(
        .DMEM_BYTES (DMEM_BYTES)
    ) u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .o_full   (o_full),
        .o_push   (o_push),
        .o_data   (o_data),
        .clr_busy (clr_busy)
    );

    rv64ie_fifo #(
        .WIDTH ($bits(rv64ie_pkg::res_t)),
        .DEPTH (2)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .pop   (pop),
        .wdata (o_data),
        .full  (o_full),
        .empty (empty),
        .rdata (res)
    );

    assign inst_pc    = res.inst_pc;
    assign next_pc    = res.next_pc;
    assign reg_write  = res.reg_write;
    assign dest_reg   = res.dest_reg;
    assign dest_value = res.dest_value;
    assign mem_write  = res.mem_write;
    assign mem_addr   = res.mem_addr;
    assign status     = res.status;

endmodule
